[design/sacl_pkg.sv]
// Package for the set-associative cache lookup block: payload structs,
// controller states and the command/status structs between the two halves.
// No dependencies.
package sacl_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned CNT_W  = 32;

  typedef struct packed {
    logic [31:0] address;
    logic        mode;
  } sacl_in_t;

  typedef struct packed {
    logic        hit;
    logic        evicted;
    logic [2:0]  way_used;
    logic [31:0] hits_total;
    logic [31:0] misses_total;
    logic [31:0] evictions_total;
    logic        last;
  } sacl_out_t;

  typedef enum logic [1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } sacl_cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_OUT
  } sacl_state_t;

  typedef struct packed {
    logic load_item;   // capture input word
    logic rd;          // issue set read
    logic upd;         // write set back and form result
    logic clr;         // clearing pass write
  } sacl_cmd_t;

  typedef struct packed {
    logic clr_done;
  } sacl_sts_t;

endpackage

[design/sacl_ctrl.sv]
// Controller for the cache lookup: clearing pass, read/update sequence per
// access, and output handshake. Uses sacl_pkg.
module sacl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               out_stall,
  output logic               out_valid,
  input  logic               item_mode,
  input  sacl_pkg::sacl_sts_t sts,
  output sacl_pkg::sacl_cmd_t cmd
);
  import sacl_pkg::*;

  sacl_state_t state_r, state_nxt;
  logic        second_r, second_nxt;   // the current access is the second one
  logic        in_acc;
  logic        out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_comb begin
    state_nxt  = state_r;
    second_nxt = second_r;
    case (state_r)
      ST_CLEAR:  if (sts.clr_done) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt  = ST_READ;
          second_nxt = 1'b0;
        end
      end
      ST_READ:   state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_acc) begin
          // A modify word runs the same access once more.
          if (item_mode && !second_r) begin
            second_nxt = 1'b1;
            state_nxt  = ST_READ;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    case (state_r)
      ST_CLEAR:  cmd.clr = 1'b1;
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_item = in_valid;
      end
      ST_READ:   cmd.rd = 1'b1;
      ST_UPDATE: cmd.upd = 1'b1;
      ST_OUT:    out_valid = 1'b1;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) in_acc |-> state_r == ST_IDLE)
    else $error("input accepted outside idle");
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
    else $error("input open while result pending");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> (state_r == ST_UPDATE))
    else $error("read not followed by update");

endmodule

[design/sacl_dp.sv]
// Datapath for the cache lookup: configuration, tag/rank/valid memory per
// set, hit search, victim choice, rank upkeep and counters. Uses sacl_pkg.
module sacl_dp #(
  parameter int unsigned MAX_SET_BITS = 8,
  parameter int unsigned WAYS         = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sacl_pkg::sacl_cmd_t  cmd,
  output sacl_pkg::sacl_sts_t  sts,
  input  sacl_pkg::sacl_in_t   in_word,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  output logic                 item_mode,
  output sacl_pkg::sacl_out_t  out_word
);
  import sacl_pkg::*;

  localparam int unsigned NSETS  = 1 << MAX_SET_BITS;
  localparam int unsigned SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RANK_W = WAY_W;
  localparam int unsigned CW     = $clog2(WAYS + 1);

  typedef struct packed {
    logic              valid;
    logic [RANK_W-1:0] rank;
    logic [31:0]       tag;
  } line_t;

  typedef line_t [WAYS-1:0] set_row_t;

  logic [3:0] set_bits_r;
  logic [4:0] block_bits_r;
  logic [3:0] ways_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= '0;
      block_bits_r <= '0;
      ways_r       <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET_BITS:   set_bits_r   <= cfg_data[3:0];
        CFG_BLOCK_BITS: block_bits_r <= cfg_data[4:0];
        CFG_WAYS:       ways_r       <= cfg_data[3:0];
        default:        ;
      endcase
    end
  end

  // Effective configuration.
  logic [4:0] s_eff, b_eff, b_max;
  logic [CW-1:0] nways;
  always_comb begin
    s_eff = (set_bits_r > 4'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS) : {1'b0, set_bits_r};
    b_max = 5'd31 - s_eff;
    b_eff = (block_bits_r > b_max) ? b_max : block_bits_r;
    if (ways_r == 4'd0) nways = CW'(1);
    else if (32'(ways_r) > WAYS) nways = CW'(WAYS);
    else nways = CW'(ways_r);
  end

  sacl_in_t item_r;
  logic [31:0] tag_r;
  logic [SET_W-1:0] set_r;
  always_ff @(posedge clk) begin
    if (cmd.load_item) item_r <= in_word;
  end
  assign item_mode = item_r.mode;

  logic [31:0] tag_c, set_full;
  always_comb begin
    tag_c    = item_r.address >> (s_eff + b_eff);
    set_full = (item_r.address >> b_eff) & ((32'd1 << s_eff) - 32'd1);
  end

  // Set memory and clearing pass.
  set_row_t mem [NSETS];
  set_row_t row_r;
  logic [SET_W:0] clr_cnt_r;
  logic [SET_W-1:0] wr_addr;
  set_row_t wr_row;
  logic wr_en;

  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clr && !clr_cnt_r[SET_W]) clr_cnt_r <= clr_cnt_r + 1'b1;
  end
  assign sts.clr_done = clr_cnt_r[SET_W] || (clr_cnt_r == (SET_W+1)'(NSETS - 1) && cmd.clr);

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      row_r <= mem[SET_W'(set_full)];
      tag_r <= tag_c;
      set_r <= SET_W'(set_full);
    end
    if (wr_en) mem[wr_addr] <= wr_row;
  end

  // Update logic.
  logic hit, found, evict;
  logic [WAY_W-1:0] way, hway, fway, vway;
  logic [RANK_W-1:0] best, hrank;
  set_row_t new_row;
  always_comb begin
    hit = 1'b0; hway = '0; found = 1'b0; fway = '0;
    best = row_r[0].rank; vway = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (CW'(w) < nways) begin
        if (row_r[w].valid && row_r[w].tag == tag_r) begin
          hit = 1'b1; hway = WAY_W'(w);
        end
        if (!row_r[w].valid) begin
          found = 1'b1; fway = WAY_W'(w);
        end
      end
    end
    for (int w = 1; w < WAYS; w++) begin
      if (CW'(w) < nways && row_r[w].rank > best) begin
        best = row_r[w].rank; vway = WAY_W'(w);
      end
    end
    evict = !hit && !found;
    way   = hit ? hway : (found ? fway : vway);
    hrank = row_r[hway].rank;
    new_row = row_r;
    for (int w = 0; w < WAYS; w++) begin
      if (CW'(w) < nways && row_r[w].valid && row_r[w].rank != RANK_W'(WAYS - 1)
          && (!hit || row_r[w].rank < hrank))
        new_row[w].rank = row_r[w].rank + 1'b1;
    end
    new_row[way].rank  = '0;
    new_row[way].valid = 1'b1;
    new_row[way].tag   = hit ? row_r[way].tag : tag_r;
  end

  always_comb begin
    wr_en   = cmd.upd || (cmd.clr && !clr_cnt_r[SET_W]);
    wr_addr = cmd.clr ? clr_cnt_r[SET_W-1:0] : set_r;
    wr_row  = cmd.clr ? set_row_t'('0) : new_row;
  end

  logic [31:0] hits_r, miss_r, ev_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r <= '0; miss_r <= '0; ev_r <= '0;
    end else if (cmd.upd) begin
      if (hit && hits_r != '1) hits_r <= hits_r + 1'b1;
      if (!hit && miss_r != '1) miss_r <= miss_r + 1'b1;
      if (evict && ev_r != '1) ev_r <= ev_r + 1'b1;
    end
  end

  logic second_r;
  always_ff @(posedge clk) begin
    if (!rst_n) second_r <= 1'b0;
    else if (cmd.load_item) second_r <= 1'b0;
    else if (cmd.upd) second_r <= item_r.mode && !second_r;
  end

  logic       res_hit_r, res_evict_r, res_last_r;
  logic [2:0] res_way_r;
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      res_hit_r   <= hit;
      res_evict_r <= evict;
      res_way_r   <= 3'(way);
      res_last_r  <= !item_r.mode || second_r;
    end
  end
  assign out_word = '{hit: res_hit_r, evicted: res_evict_r, way_used: res_way_r,
                      hits_total: hits_r, misses_total: miss_r,
                      evictions_total: ev_r, last: res_last_r};

  assert property (@(posedge clk) disable iff (!rst_n) cmd.upd |-> !cmd.clr)
    else $error("update during clear");
  assert property (@(posedge clk) disable iff (!rst_n) cmd.upd && hit |-> !evict)
    else $error("eviction on hit");
  assert property (@(posedge clk) disable iff (!rst_n) cmd.upd |-> CW'(way) < nways)
    else $error("way outside those in use");

endmodule

[design/set_assoc_cache_lru_lookup.sv]
// Tag-only set-associative cache with exact LRU ranks. After reset a clearing
// pass empties the set memory before the first word is taken. Each access is
// one read-modify-write of the set's row in the set memory: the word is taken
// in an idle cycle, then read, update and the result word follow, and the block
// takes no new word until the result is accepted; a modify-mode word repeats
// read, update and result and gives two results.
// Uses sacl_pkg, sacl_ctrl and sacl_dp.
module set_assoc_cache_lru_lookup #(
  parameter int unsigned MAX_SET_BITS = 8,
  parameter int unsigned WAYS         = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sacl_pkg::sacl_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sacl_pkg::sacl_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import sacl_pkg::*;

  sacl_cmd_t cmd;
  sacl_sts_t sts;
  logic      item_mode;

  assign cfg_ready = 1'b1;

  sacl_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_stall, .out_valid,
    .item_mode, .sts, .cmd
  );

  sacl_dp #(.MAX_SET_BITS(MAX_SET_BITS), .WAYS(WAYS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_word(in_data),
    .cfg_we(cfg_valid), .cfg_index, .cfg_data, .item_mode, .out_word(out_data)
  );

endmodule
